### sv/vr_pkg.sv
// Shared constants, types and the arctangent table of the vector rotation block.
// Used by every module of the block; depends on nothing else.
package vr_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int STAGES       = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int GUARD_BITS   = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_ROT      = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

  // Datapath word: coordinate plus guard bits plus headroom for CORDIC growth.
  localparam int DATA_W  = COORD_WIDTH + GUARD_BITS + 3;
  localparam int ZW      = 32;
  localparam int PX_W    = COORD_WIDTH + 1;
  localparam int GAIN_W  = 33;
  localparam int PROD_W  = PX_W + GAIN_W;
  localparam int RND_W   = DATA_W - GUARD_BITS;

  localparam logic signed [GAIN_W-1:0] INV_GAIN = 33'sh0_9B74_EDA8;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam logic [ZW-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic signed [ZW-1:0]     z;
  } rot_beat_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic                          clipped;
  } res_t;

endpackage

### sv/vr_prescale.sv
// Front end: quarter-turn folding of the vector and angle, then inverse-gain scaling.
// Two register stages; uses vr_pkg.
module vr_prescale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [vr_pkg::COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [vr_pkg::COORD_WIDTH-1:0] in_vec_y,
  input  logic        [vr_pkg::ANGLE_WIDTH-1:0] in_turn_angle,
  output vr_pkg::rot_beat_t                     rot_out
);

  logic                              a_valid_r;
  logic signed [vr_pkg::PX_W-1:0]    a_px_r, a_px_nxt;
  logic signed [vr_pkg::PX_W-1:0]    a_py_r, a_py_nxt;
  logic signed [vr_pkg::ZW-1:0]      a_z_r, a_z_nxt;
  vr_pkg::rot_beat_t                 b_r, b_nxt;

  logic        [vr_pkg::ANGLE_WIDTH-1:0] ang_bias;
  logic        [vr_pkg::ANGLE_WIDTH-1:0] resid;
  vr_pkg::quad_t                         quad;
  logic signed [vr_pkg::PX_W-1:0]        ex, ey;
  logic signed [vr_pkg::PROD_W-1:0]      prod_x, prod_y, rnd_x, rnd_y;

  assign ang_bias = in_turn_angle + vr_pkg::ANGLE_WIDTH'(16'h2000);
  assign quad     = vr_pkg::quad_t'(ang_bias[vr_pkg::ANGLE_WIDTH-1 -: 2]);
  assign resid    = in_turn_angle - {ang_bias[vr_pkg::ANGLE_WIDTH-1 -: 2],
                                     {(vr_pkg::ANGLE_WIDTH-2){1'b0}}};
  assign ex       = vr_pkg::PX_W'(in_vec_x);
  assign ey       = vr_pkg::PX_W'(in_vec_y);

  always_comb begin
    a_z_nxt = {resid, {(vr_pkg::ZW-vr_pkg::ANGLE_WIDTH){1'b0}}};
    case (quad)
      vr_pkg::QUAD_90: begin
        a_px_nxt = -ey;
        a_py_nxt = ex;
      end
      vr_pkg::QUAD_180: begin
        a_px_nxt = -ex;
        a_py_nxt = -ey;
      end
      vr_pkg::QUAD_270: begin
        a_px_nxt = ey;
        a_py_nxt = -ex;
      end
      default: begin
        a_px_nxt = ex;
        a_py_nxt = ey;
      end
    endcase
  end

  assign prod_x = vr_pkg::PROD_W'(a_px_r) * vr_pkg::PROD_W'(vr_pkg::INV_GAIN);
  assign prod_y = vr_pkg::PROD_W'(a_py_r) * vr_pkg::PROD_W'(vr_pkg::INV_GAIN);
  assign rnd_x  = prod_x + vr_pkg::PROD_W'(1 << (vr_pkg::GUARD_BITS - 1));
  assign rnd_y  = prod_y + vr_pkg::PROD_W'(1 << (vr_pkg::GUARD_BITS - 1));

  always_comb begin
    b_nxt.valid = a_valid_r;
    b_nxt.cx    = vr_pkg::DATA_W'(rnd_x >>> vr_pkg::GUARD_BITS);
    b_nxt.cy    = vr_pkg::DATA_W'(rnd_y >>> vr_pkg::GUARD_BITS);
    b_nxt.z     = a_z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_px_r    <= '0;
      a_py_r    <= '0;
      a_z_r     <= '0;
      b_r       <= '0;
    end else if (en) begin
      a_valid_r <= in_valid;
      a_px_r    <= a_px_nxt;
      a_py_r    <= a_py_nxt;
      a_z_r     <= a_z_nxt;
      b_r       <= b_nxt;
    end
  end

  assign rot_out = b_r;

endmodule

### sv/vr_cordic.sv
// Chain of CORDIC micro-rotation stages, one register stage per iteration.
// Uses vr_pkg for the datapath widths and the arctangent table.
module vr_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  vr_pkg::rot_beat_t rot_in,
  output vr_pkg::rot_beat_t rot_out
);

  vr_pkg::rot_beat_t stg_r   [vr_pkg::NUM_ROT];
  vr_pkg::rot_beat_t stg_nxt [vr_pkg::NUM_ROT];

  for (genvar i = 0; i < vr_pkg::NUM_ROT; i++) begin : g_rot
    vr_pkg::rot_beat_t                prv;
    logic signed [vr_pkg::DATA_W-1:0] dx, dy;
    logic signed [vr_pkg::ZW-1:0]     ang;

    if (i == 0) begin : g_first
      assign prv = rot_in;
    end else begin : g_next
      assign prv = stg_r[i-1];
    end

    assign dx  = $signed(prv.cy) >>> i;
    assign dy  = $signed(prv.cx) >>> i;
    assign ang = $signed(vr_pkg::ATAN_TABLE[i]);

    always_comb begin
      stg_nxt[i].valid = prv.valid;
      if (!prv.z[vr_pkg::ZW-1]) begin
        stg_nxt[i].cx = prv.cx - dx;
        stg_nxt[i].cy = prv.cy + dy;
        stg_nxt[i].z  = prv.z - ang;
      end else begin
        stg_nxt[i].cx = prv.cx + dx;
        stg_nxt[i].cy = prv.cy - dy;
        stg_nxt[i].z  = prv.z + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[i] <= '0;
      end else if (en) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign rot_out = stg_r[vr_pkg::NUM_ROT-1];

endmodule

### sv/vr_output.sv
// Output end: rounding and saturation to the coordinate format, output register and skid stage.
// Uses vr_pkg; drives the pipeline enable for the stages in front of it.
module vr_output (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vr_pkg::rot_beat_t                     rot_in,
  output logic                                  en,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vr_pkg::COORD_WIDTH-1:0] out_rot_x,
  output logic signed [vr_pkg::COORD_WIDTH-1:0] out_rot_y,
  output logic                                  out_clipped
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  vr_pkg::res_t out_data_r, out_data_nxt;
  vr_pkg::res_t skid_data_r, skid_data_nxt;
  vr_pkg::res_t res_c;
  logic         take;
  logic [vr_pkg::COORD_WIDTH:0] sat_x, sat_y;

  function automatic logic [vr_pkg::COORD_WIDTH:0] round_sat(
    input logic [vr_pkg::DATA_W-1:0] v
  );
    logic [vr_pkg::DATA_W-1:0]                          rv;
    logic [vr_pkg::RND_W-1:0]                           sh;
    logic [vr_pkg::RND_W-vr_pkg::COORD_WIDTH:0]         top;
    logic [vr_pkg::COORD_WIDTH:0]                       res;
    rv  = v + vr_pkg::DATA_W'(1 << (vr_pkg::GUARD_BITS - 1));
    sh  = rv[vr_pkg::DATA_W-1:vr_pkg::GUARD_BITS];
    top = sh[vr_pkg::RND_W-1:vr_pkg::COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      res = {1'b0, sh[vr_pkg::COORD_WIDTH-1:0]};
    end else if (sh[vr_pkg::RND_W-1]) begin
      res = {1'b1, vr_pkg::COORD_MIN};
    end else begin
      res = {1'b1, vr_pkg::COORD_MAX};
    end
    return res;
  endfunction

  assign sat_x         = round_sat(rot_in.cx);
  assign sat_y         = round_sat(rot_in.cy);
  assign res_c.rot_x   = sat_x[vr_pkg::COORD_WIDTH-1:0];
  assign res_c.rot_y   = sat_y[vr_pkg::COORD_WIDTH-1:0];
  assign res_c.clipped = sat_x[vr_pkg::COORD_WIDTH] | sat_y[vr_pkg::COORD_WIDTH];

  assign take = rot_in.valid & ~skid_valid_r;

  // The skid stage holds a beat that arrived while the output register was stalled.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = take;
        out_data_nxt  = res_c;
      end
    end else if (take) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign en          = ~skid_valid_r;
  assign out_valid   = out_valid_r;
  assign out_rot_x   = out_data_r.rot_x;
  assign out_rot_y   = out_data_r.rot_y;
  assign out_clipped = out_data_r.clipped;

endmodule

### sv/vector_rotation.sv
// Vector rotation block: turns a fixed-point 2D vector counter-clockwise by an angle.
// Instantiates vr_prescale, vr_cordic and vr_output; uses vr_pkg.
//
// Input channel: in_vec_x, in_vec_y (signed, 8 fraction bits) and in_turn_angle
// (65536 units per turn) move as one beat on in_valid/in_ready.
// Result channel: out_rot_x, out_rot_y (same format, saturated) and out_clipped
// move as one beat on out_valid/out_ready. Every input beat gives one result beat.
// Path: an accepted input beat passes two front-end stages (quadrant fold, gain
// multiply), one stage per micro-rotation and the output register; the front-end
// and micro-rotation stages advance together on one enable.
// Throughput: one beat per cycle while in_ready is high.
// Stall: when the receiver holds out_ready low, the output register keeps its beat
// and one more result lands in the skid stage; while the skid stage is full,
// in_ready is low and the whole pipeline holds. in_ready is a register output.
// Reset: synchronous, active low; it empties the pipeline and the output stages,
// and in_ready is high on the first cycle after reset.
module vector_rotation (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vr_pkg::COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [vr_pkg::COORD_WIDTH-1:0] in_vec_y,
  input  logic        [vr_pkg::ANGLE_WIDTH-1:0] in_turn_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vr_pkg::COORD_WIDTH-1:0] out_rot_x,
  output logic signed [vr_pkg::COORD_WIDTH-1:0] out_rot_y,
  output logic                                  out_clipped
);

  logic              en;
  vr_pkg::rot_beat_t pre_beat;
  vr_pkg::rot_beat_t rot_beat;

  vr_prescale u_prescale (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_turn_angle (in_turn_angle),
    .rot_out       (pre_beat)
  );

  vr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .rot_in  (pre_beat),
    .rot_out (rot_beat)
  );

  vr_output u_output (
    .clk         (clk),
    .rst_n       (rst_n),
    .rot_in      (rot_beat),
    .en          (en),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rot_x   (out_rot_x),
    .out_rot_y   (out_rot_y),
    .out_clipped (out_clipped)
  );

  assign in_ready = en;

endmodule

### sv/vr_checker.sv
// Port-level checks for the vector rotation block, bound to its top level.
// Uses vr_pkg for the saturation limits.
module vr_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic signed [vr_pkg::COORD_WIDTH-1:0] in_vec_x,
  input logic signed [vr_pkg::COORD_WIDTH-1:0] in_vec_y,
  input logic        [vr_pkg::ANGLE_WIDTH-1:0] in_turn_angle,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [vr_pkg::COORD_WIDTH-1:0] out_rot_x,
  input logic signed [vr_pkg::COORD_WIDTH-1:0] out_rot_y,
  input logic                                  out_clipped
);

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rot_x) && $stable(out_rot_y)
      && $stable(out_clipped))
    else $error("stalled result beat changed");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held off with no result waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input held off without a receiver stall");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_rot_x == vr_pkg::COORD_MAX || out_rot_x == vr_pkg::COORD_MIN ||
      out_rot_y == vr_pkg::COORD_MAX || out_rot_y == vr_pkg::COORD_MIN)
    else $error("clipped flag without a saturated component");

endmodule

bind vector_rotation vr_checker u_vr_checker (.*);

### dv/vector_rotation_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for vector_rotation: directed and random vectors with random idling.
// A clocked driver and monitor check every result beat against a bit-exact predictor.
// Depends on vr_pkg and vector_rotation.
module vector_rotation_tb;

  localparam int CW = vr_pkg::COORD_WIDTH;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int CALM_TAIL = 200;
  localparam longint INV_GAIN_Q32 = 64'h0000_0000_9B74_EDA8;
  localparam longint ATAN_UNITS [24] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
    'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
    'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
    'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051
  };

  typedef struct {
    logic signed [CW-1:0]                  x;
    logic signed [CW-1:0]                  y;
    logic        [vr_pkg::ANGLE_WIDTH-1:0] ang;
    bit                                    drain_first;
  } vec_item_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [CW-1:0]                  in_vec_x = '0;
  logic signed [CW-1:0]                  in_vec_y = '0;
  logic        [vr_pkg::ANGLE_WIDTH-1:0] in_turn_angle = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [CW-1:0]                  out_rot_x;
  logic signed [CW-1:0]                  out_rot_y;
  logic                                  out_clipped;

  vec_item_t    vector_q[$];
  vr_pkg::res_t predicted_rot_q[$];
  int           n_items = 0;
  int           sent_cnt = 0;
  int           mismatch_cnt = 0;
  int           send_gap = 0;
  int           stall_gap = 0;
  longint       cycle_cnt = 0;

  vector_rotation i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_turn_angle (in_turn_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rot_x     (out_rot_x),
    .out_rot_y     (out_rot_y),
    .out_clipped   (out_clipped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint saturate_coord(longint v, ref bit sat);
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    r = (v + (longint'(1) <<< 15)) >>> 16;
    if (r > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (r < lo) begin
      sat = 1'b1;
      return lo;
    end
    return r;
  endfunction

  function automatic vr_pkg::res_t rotate_vector(logic signed [CW-1:0] vx,
                                                 logic signed [CW-1:0] vy,
                                                 logic [vr_pkg::ANGLE_WIDTH-1:0] ang);
    longint        x;
    longint        y;
    longint        a;
    longint        r;
    longint        px;
    longint        py;
    longint        cx;
    longint        cy;
    longint        z;
    longint        dx;
    longint        dy;
    vr_pkg::quad_t q;
    bit            sat;
    vr_pkg::res_t  res;
    x = vx;
    y = vy;
    a = ang;
    sat = 1'b0;
    q = vr_pkg::quad_t'(((a + 'h2000) >> 14) & 3);
    r = a - longint'(q) * longint'('h4000);
    if (r >= longint'('h8000)) r = r - longint'('h10000);
    case (q)
      vr_pkg::QUAD_90: begin
        px = -y;
        py = x;
      end
      vr_pkg::QUAD_180: begin
        px = -x;
        py = -y;
      end
      vr_pkg::QUAD_270: begin
        px = y;
        py = -x;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
    cx = (px * INV_GAIN_Q32 + (longint'(1) <<< 15)) >>> 16;
    cy = (py * INV_GAIN_Q32 + (longint'(1) <<< 15)) >>> 16;
    z = r * 65536;
    for (int i = 0; i < vr_pkg::STAGES && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - ATAN_UNITS[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + ATAN_UNITS[i];
      end
    end
    res.rot_x = CW'(saturate_coord(cx, sat));
    res.rot_y = CW'(saturate_coord(cy, sat));
    res.clipped = sat;
    return res;
  endfunction

  function automatic bit calm_phase(int cnt);
    return (cnt >= n_items - CALM_TAIL) || (((cnt >> 7) % 3) == 1);
  endfunction

  task automatic add_vector(int x, int y, int ang, bit drain_first = 1'b0);
    vec_item_t it;
    it.x = CW'(x);
    it.y = CW'(y);
    it.ang = vr_pkg::ANGLE_WIDTH'(ang);
    it.drain_first = drain_first;
    vector_q.push_back(it);
  endtask

  // Sender: a new beat is presented only when no beat is pending or the last one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_rot_q.push_back(rotate_vector(in_vec_x, in_vec_y, in_turn_angle));
        void'(vector_q.pop_front());
        sent_cnt++;
        if (!calm_phase(sent_cnt) && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 16);
        end
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (vector_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (vector_q[0].drain_first && predicted_rot_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_vec_x <= vector_q[0].x;
          in_vec_y <= vector_q[0].y;
          in_turn_angle <= vector_q[0].ang;
        end
      end
    end
  end

  // Receiver: checks each accepted result beat and stalls in random bursts.
  always @(posedge clk) begin
    vr_pkg::res_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_rot_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected result beat: x=%0d y=%0d clipped=%0b",
                     out_rot_x, out_rot_y, out_clipped);
          end
        end else begin
          exp_res = predicted_rot_q.pop_front();
          if (out_rot_x !== exp_res.rot_x || out_rot_y !== exp_res.rot_y ||
              out_clipped !== exp_res.clipped) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: expected x=%0d y=%0d clipped=%0b, got x=%0d y=%0d clipped=%0b",
                       exp_res.rot_x, exp_res.rot_y, exp_res.clipped,
                       out_rot_x, out_rot_y, out_clipped);
            end
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm_phase(sent_cnt) && $urandom_range(0, 9) == 0) begin
          stall_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int base;
    int sel;
    // Directed part: zero vectors, quadrant boundaries, full-scale and saturating vectors.
    add_vector(0, 0, 'h0000);
    add_vector(0, 0, 'h1234);
    add_vector('h100, 0, 'h0000);
    add_vector('h100, 0, 'h4000);
    add_vector('h100, 0, 'h8000);
    add_vector('h100, 0, 'hC000);
    add_vector('h100, 0, 'h2000);
    add_vector('h100, 0, 'h1FFF);
    add_vector('h100, 0, 'hFFFF);
    add_vector('h100, 0, 'hE000);
    add_vector('h100, 0, 'h6000);
    add_vector(32767, 32767, 'h2000);
    add_vector(-32768, -32768, 'h2000);
    add_vector(-32768, 0, 'h8000);
    add_vector(32767, 0, 'h0000);
    add_vector(-32768, 0, 'h0000);
    add_vector(0, 32767, 'h4000);
    add_vector(0, -32768, 'hC000);
    add_vector(32767, -32768, 'hFFFF);
    add_vector(-1, -1, 'h5A5A);
    add_vector(1, 1, 'hA5A5);
    add_vector('h5555, -'h2AAA, 'h0001);
    add_vector(-32768, 32767, 'h8000, 1'b1);
    for (int n = 0; n < 1650; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        add_vector($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), n == 0 || n == 800);
      end else if (sel < 8) begin
        add_vector(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                   $urandom_range(0, 65535));
      end else if (sel < 9) begin
        base = $urandom_range(0, 7) * 'h2000;
        add_vector($urandom_range(0, 65535), $urandom_range(0, 65535),
                   (base + int'($urandom_range(0, 8)) - 4) & 'hFFFF);
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          add_vector(0, 0, $urandom_range(0, 65535));
        end else begin
          add_vector($urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 255))
                                          : -32768 + int'($urandom_range(0, 255)),
                     $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 255))
                                          : -32768 + int'($urandom_range(0, 255)),
                     $urandom_range(0, 65535));
        end
      end
    end
    n_items = vector_q.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (!(sent_cnt == n_items && predicted_rot_q.size() == 0)) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && predicted_rot_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
